@@ src/i2cmtq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package i2cmtq_pkg;

  // host operation codes
  localparam logic [2:0] OP_BEGIN_WRITE = 3'd0;
  localparam logic [2:0] OP_BEGIN_READ  = 3'd1;
  localparam logic [2:0] OP_QUEUE_BYTE  = 3'd2;
  localparam logic [2:0] OP_REQUEST     = 3'd3;
  localparam logic [2:0] OP_POP         = 3'd4;
  localparam logic [2:0] OP_END_WRITE   = 3'd5;
  localparam logic [2:0] OP_END_READ    = 3'd6;
  localparam logic [2:0] OP_BUS_EVENT   = 3'd7;

  // commands to the byte engine
  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_START    = 3'd1;
  localparam logic [2:0] CMD_SEND     = 3'd2;
  localparam logic [2:0] CMD_CONTINUE = 3'd3;
  localparam logic [2:0] CMD_ACK      = 3'd4;
  localparam logic [2:0] CMD_NACK     = 3'd5;
  localparam logic [2:0] CMD_RELEASE  = 3'd6;
  localparam logic [2:0] CMD_STOP     = 3'd7;

  // engine status codes, bits 7..3 of the status byte
  localparam logic [4:0] SC_START         = 5'h01;
  localparam logic [4:0] SC_RESTART       = 5'h02;
  localparam logic [4:0] SC_MT_SLA_ACK    = 5'h03;
  localparam logic [4:0] SC_MT_SLA_NACK   = 5'h04;
  localparam logic [4:0] SC_MT_DATA_ACK   = 5'h05;
  localparam logic [4:0] SC_MT_DATA_NACK  = 5'h06;
  localparam logic [4:0] SC_MR_SLA_ACK    = 5'h08;
  localparam logic [4:0] SC_MR_SLA_NACK   = 5'h09;
  localparam logic [4:0] SC_MR_DATA_ACK   = 5'h0A;
  localparam logic [4:0] SC_MR_DATA_NACK  = 5'h0B;

  typedef enum logic [1:0] {
    EV_START   = 2'd0,
    EV_TX_DONE = 2'd1,
    EV_RECEIVE = 2'd2,
    EV_OTHER   = 2'd3
  } ev_class_t;

  // queue control: push advances head, write stores data at head, pop advances tail
  typedef struct packed {
    logic push;
    logic write;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic one_left;
  } q_stat_t;

  function automatic ev_class_t classify_status(input logic [4:0] code);
    ev_class_t c;
    case (code) inside
      SC_START, SC_RESTART: c = EV_START;
      SC_MT_SLA_ACK, SC_MT_SLA_NACK, SC_MT_DATA_ACK, SC_MT_DATA_NACK,
      SC_MR_SLA_ACK, SC_MR_SLA_NACK: c = EV_TX_DONE;
      SC_MR_DATA_ACK, SC_MR_DATA_NACK: c = EV_RECEIVE;
      default: c = EV_OTHER;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ src/i2cmtq_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module i2cmtq_queue
  import i2cmtq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rd_en,
  input  logic       rd_adv,
  input  q_ctl_t     ctl,
  input  logic [7:0] wr_data,
  output logic [7:0] rd_data,
  output q_stat_t    stat
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data_r;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic          lwp_r, lwp_nxt;
  logic [IW-1:0] tail_inc;
  logic          same;

  function automatic logic [IW-1:0] inc(input logic [IW-1:0] i);
    return (i == LAST) ? '0 : i + 1'b1;
  endfunction

  assign tail_inc = inc(tail_r);
  assign same     = (head_r == tail_r);

  always_comb begin
    head_nxt = ctl.push ? inc(head_r) : head_r;
    tail_nxt = ctl.pop ? tail_inc : tail_r;
    if (ctl.push) begin
      lwp_nxt = 1'b1;
    end else if (ctl.pop) begin
      lwp_nxt = 1'b0;
    end else begin
      lwp_nxt = lwp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      lwp_r  <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      lwp_r  <= lwp_nxt;
    end
  end

  // storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (ctl.write) begin
      mem[head_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_adv ? tail_inc : tail_r];
    end
  end

  assign rd_data       = rd_data_r;
  assign stat.empty    = same && !lwp_r;
  assign stat.full     = same && lwp_r;
  assign stat.one_left = (tail_inc == head_r);

endmodule
`default_nettype wire

@@ src/i2c_master_transfer_queue_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Host-side sequencer for an I2C master byte engine. A transfer is taken when
// start is high and busy is low; busy then stays high for exactly one cycle,
// and no new transfer is taken while it is high. The accepting cycle issues
// the synchronous read of both queue memories (transmit entry at the tail, or
// the next one when a transmit acknowledge retires an entry; receive entry at
// the tail), the busy cycle decides the command and writes back queue
// pointers, queue memories and the pending receive count. The result shows on
// the out_ ports for exactly one cycle with out_valid high, in the cycle in which
// busy drops; the receiver cannot stall, so it must take every result as it comes.
// A new transfer may be taken in that same cycle. Host operations that cannot
// proceed (queue full, queue not drained, reads still pending) return
// out_accepted low and change nothing; retry them later. The pending count
// saturates at 255. A received byte that finds the receive queue full still
// goes in, the oldest byte is dropped and out_overrun is set. Queue memories
// are not cleared at reset; reading an entry never written is undefined.
module i2c_master_transfer_queue_top
  import i2cmtq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_operation,
  input  logic [6:0] in_slave_address,
  input  logic [7:0] in_host_byte,
  input  logic [7:0] in_request_count,
  input  logic [7:0] in_bus_status,
  input  logic [7:0] in_bus_rx_byte,
  output logic       out_valid,
  output logic       out_accepted,
  output logic [2:0] out_bus_command,
  output logic       out_load_data,
  output logic [7:0] out_tx_byte_out,
  output logic [7:0] out_popped_byte,
  output logic       out_rx_available,
  output logic [7:0] out_pending_receive,
  output logic       out_overrun
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // captured transfer
  logic [2:0] op_r;
  logic [6:0] addr_r;
  logic [7:0] hbyte_r;
  logic [7:0] count_r;
  logic [4:0] status_r;
  logic [7:0] rxb_r;

  logic [7:0] rem_r, rem_nxt;

  // queue interface
  q_ctl_t     tx_ctl, rx_ctl;
  q_stat_t    tx_stat, rx_stat;
  logic [7:0] tx_wdata, tx_rdata, rx_rdata;
  logic       tx_rd_adv;

  // result
  logic       acc, load, ovr, rx_avail;
  logic [2:0] cmd;
  logic [7:0] txo, popped;
  logic [8:0] rem_sum;
  logic       tx_left;
  ev_class_t  ev_exec;

  logic       out_valid_r;
  logic       out_accepted_r, out_load_data_r, out_rx_available_r, out_overrun_r;
  logic [2:0] out_bus_command_r;
  logic [7:0] out_tx_byte_out_r, out_popped_byte_r, out_pending_receive_r;

  assign busy   = (state_r == ST_EXEC);
  assign accept = start && !busy;

  // transmit read targets the next entry when this event retires the current one
  assign tx_rd_adv = (in_operation == OP_BUS_EVENT) &&
                     (classify_status(in_bus_status[7:3]) == EV_TX_DONE) &&
                     !tx_stat.empty;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= busy;
      if (busy) begin
        rem_r <= rem_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_operation;
      addr_r   <= in_slave_address;
      hbyte_r  <= in_host_byte;
      count_r  <= in_request_count;
      status_r <= in_bus_status[7:3];
      rxb_r    <= in_bus_rx_byte;
    end
  end

  assign ev_exec = classify_status(status_r);
  assign rem_sum = {1'b0, rem_r} + {1'b0, count_r};

  // decision and write-back, all in the busy cycle
  always_comb begin
    acc      = 1'b1;
    cmd      = CMD_NONE;
    load     = 1'b0;
    txo      = '0;
    popped   = '0;
    ovr      = 1'b0;
    rem_nxt  = rem_r;
    tx_ctl   = '0;
    rx_ctl   = '0;
    tx_wdata = hbyte_r;
    tx_left  = 1'b0;
    unique case (op_r)
      OP_BEGIN_WRITE, OP_BEGIN_READ: begin
        if (!tx_stat.empty) begin
          acc = 1'b0;
        end else begin
          tx_wdata     = {addr_r, op_r[0]};
          tx_ctl.push  = 1'b1;
          tx_ctl.write = 1'b1;
          cmd          = CMD_START;
        end
      end
      OP_QUEUE_BYTE: begin
        if (tx_stat.empty) begin
          // straight to the engine; counts as one entry, nothing stored
          tx_ctl.push = 1'b1;
          load        = 1'b1;
          txo         = hbyte_r;
          cmd         = CMD_SEND;
        end else if (tx_stat.full) begin
          acc = 1'b0;
        end else begin
          tx_ctl.push  = 1'b1;
          tx_ctl.write = 1'b1;
        end
      end
      OP_REQUEST: begin
        rem_nxt = rem_sum[8] ? 8'hFF : rem_sum[7:0];
      end
      OP_POP: begin
        if (!rx_stat.empty) begin
          popped     = rx_rdata;
          rx_ctl.pop = 1'b1;
        end
      end
      OP_END_WRITE: begin
        if (!tx_stat.empty) acc = 1'b0;
        else cmd = CMD_STOP;
      end
      OP_END_READ: begin
        if (rem_r != '0) acc = 1'b0;
        else cmd = CMD_STOP;
      end
      OP_BUS_EVENT: begin
        case (ev_exec)
          EV_START, EV_TX_DONE: begin
            if (ev_exec == EV_TX_DONE && !tx_stat.empty) begin
              tx_ctl.pop = 1'b1;
              tx_left    = !tx_stat.one_left;
            end else begin
              tx_left    = !tx_stat.empty;
            end
            if (tx_left) begin
              load = 1'b1;
              txo  = tx_rdata;
              cmd  = CMD_CONTINUE;
            end else if (rem_r == 8'd1) begin
              cmd = CMD_NACK;
            end else if (rem_r > 8'd1) begin
              cmd = CMD_CONTINUE;
            end else begin
              cmd = CMD_RELEASE;
            end
          end
          EV_RECEIVE: begin
            if (rem_r != '0) begin
              rx_ctl.push  = 1'b1;
              rx_ctl.write = 1'b1;
              rx_ctl.pop   = rx_stat.full;
              ovr          = rx_stat.full;
              rem_nxt      = rem_r - 8'd1;
            end
            if (rem_nxt > 8'd1) cmd = CMD_ACK;
            else if (rem_nxt == 8'd1) cmd = CMD_NACK;
            else cmd = CMD_RELEASE;
          end
          default: cmd = CMD_CONTINUE;
        endcase
      end
      default: acc = 1'b0;
    endcase
    if (!busy) begin
      tx_ctl = '0;
      rx_ctl = '0;
    end
  end

  // receive queue occupancy after this step
  assign rx_avail = rx_ctl.push ? 1'b1 :
                    rx_ctl.pop  ? !rx_stat.one_left : !rx_stat.empty;

  always_ff @(posedge clk) begin
    if (busy) begin
      out_accepted_r        <= acc;
      out_bus_command_r     <= cmd;
      out_load_data_r       <= load;
      out_tx_byte_out_r     <= txo;
      out_popped_byte_r     <= popped;
      out_rx_available_r    <= rx_avail;
      out_pending_receive_r <= rem_nxt;
      out_overrun_r         <= ovr;
    end
  end

  i2cmtq_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_tx_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_adv  (tx_rd_adv),
    .ctl     (tx_ctl),
    .wr_data (tx_wdata),
    .rd_data (tx_rdata),
    .stat    (tx_stat)
  );

  i2cmtq_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_rx_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_adv  (1'b0),
    .ctl     (rx_ctl),
    .wr_data (rxb_r),
    .rd_data (rx_rdata),
    .stat    (rx_stat)
  );

  assign out_valid           = out_valid_r;
  assign out_accepted        = out_accepted_r;
  assign out_bus_command     = out_bus_command_r;
  assign out_load_data       = out_load_data_r;
  assign out_tx_byte_out     = out_tx_byte_out_r;
  assign out_popped_byte     = out_popped_byte_r;
  assign out_rx_available    = out_rx_available_r;
  assign out_pending_receive = out_pending_receive_r;
  assign out_overrun         = out_overrun_r;

  // every taken transfer yields exactly one result, after its busy cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy ##1 out_valid)
    else $error("transfer did not produce a result");

  // the busy cycle never repeats, so memory reads and write-backs never overlap
  a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  // a refused operation issues no command and loads nothing
  a_refused_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_accepted) |-> (out_bus_command == CMD_NONE && !out_load_data))
    else $error("refused transfer issued a command");

  // overrun only comes with a receive that leaves the queue occupied
  a_overrun_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overrun) |-> out_rx_available)
    else $error("overrun with empty receive queue");

endmodule
`default_nettype wire

@@ bench/i2c_master_transfer_queue_top_tb.sv @@
`timescale 1ns / 1ps
// Bench for the I2C master transfer sequencer. A local model of the queues and
// the pending receive count predicts one reply per transfer; a checker compares
// every out_valid cycle against the oldest prediction, field by field.
module i2c_master_transfer_queue_top_tb;
  import i2cmtq_pkg::*;

  // arbitration-lost code: any status outside the known set
  localparam logic [4:0] SC_ARB_LOST = 5'h07;
  // cycles with no transfer in or reply out before the run is declared hung
  localparam int unsigned HANG_LIMIT = 500;
  localparam int unsigned MAX_PRINTED = 100;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [2:0] in_operation;
  logic [6:0] in_slave_address;
  logic [7:0] in_host_byte;
  logic [7:0] in_request_count;
  logic [7:0] in_bus_status;
  logic [7:0] in_bus_rx_byte;
  logic       out_valid;
  logic       out_accepted;
  logic [2:0] out_bus_command;
  logic       out_load_data;
  logic [7:0] out_tx_byte_out;
  logic [7:0] out_popped_byte;
  logic       out_rx_available;
  logic [7:0] out_pending_receive;
  logic       out_overrun;

  typedef struct packed {
    logic       accepted;
    logic [2:0] command;
    logic       load_data;
    logic [7:0] tx_byte;
    logic [7:0] popped;
    logic       rx_available;
    logic [7:0] pending;
    logic       overrun;
  } engine_reply_t;

  // Sequencer state as the bench sees it. Pointers are 4 bits wide, so they
  // wrap at the 16-entry queue depth by themselves.
  logic [7:0]  tx_mem [16];
  logic [15:0] tx_written;    // slots holding real data, never cleared
  logic [3:0]  tx_wr, tx_rd;
  logic        tx_pushed;     // last queue op was a push: equal pointers mean full
  logic [7:0]  rx_mem [16];
  logic [3:0]  rx_wr, rx_rd;
  logic        rx_pushed;
  logic [7:0]  pend_count;

  engine_reply_t engine_replies[$];   // predicted replies, oldest first
  int unsigned   items_sent;
  int unsigned   error_count;
  int unsigned   stall_cycles;
  bit            idle_on;

  i2c_master_transfer_queue_top DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_slave_address    (in_slave_address),
    .in_host_byte        (in_host_byte),
    .in_request_count    (in_request_count),
    .in_bus_status       (in_bus_status),
    .in_bus_rx_byte      (in_bus_rx_byte),
    .out_valid           (out_valid),
    .out_accepted        (out_accepted),
    .out_bus_command     (out_bus_command),
    .out_load_data       (out_load_data),
    .out_tx_byte_out     (out_tx_byte_out),
    .out_popped_byte     (out_popped_byte),
    .out_rx_available    (out_rx_available),
    .out_pending_receive (out_pending_receive),
    .out_overrun         (out_overrun)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit tx_is_empty();
    return tx_wr == tx_rd && !tx_pushed;
  endfunction

  function automatic bit rx_is_empty();
    return rx_wr == rx_rd && !rx_pushed;
  endfunction

  // Status byte class from bits 7..3; low bits carry no meaning.
  function automatic ev_class_t kind_of(input logic [7:0] status);
    case (status[7:3])
      SC_START, SC_RESTART: return EV_START;
      SC_MT_SLA_ACK, SC_MT_SLA_NACK, SC_MT_DATA_ACK, SC_MT_DATA_NACK,
      SC_MR_SLA_ACK, SC_MR_SLA_NACK: return EV_TX_DONE;
      SC_MR_DATA_ACK, SC_MR_DATA_NACK: return EV_RECEIVE;
      default: return EV_OTHER;
    endcase
  endfunction

  // True when this status would make the block load a transmit slot that
  // was never written (a start event right after a direct send).
  function automatic bit reads_unwritten_slot(input logic [7:0] status);
    ev_class_t  k;
    logic [3:0] rd;
    logic       pushed;
    k = kind_of(status);
    rd = tx_rd;
    pushed = tx_pushed;
    if (k != EV_START && k != EV_TX_DONE) return 1'b0;
    if (k == EV_TX_DONE && !(tx_wr == rd && !pushed)) begin
      rd = rd + 4'd1;
      pushed = 1'b0;
    end
    return !(tx_wr == rd && !pushed) && !tx_written[rd];
  endfunction

  // One host operation or bus event through the sequencer; updates the local
  // state and returns the reply the block must give.
  function automatic engine_reply_t predict_sequencer(
    input logic [2:0] op, input logic [6:0] addr, input logic [7:0] hbyte,
    input logic [7:0] count, input logic [7:0] status, input logic [7:0] rx_byte);
    engine_reply_t r;
    ev_class_t     k;
    logic [8:0]    sum;
    r = '0;
    r.accepted = 1'b1;
    case (op)
      OP_BEGIN_WRITE, OP_BEGIN_READ: begin
        if (!tx_is_empty()) begin
          r.accepted = 1'b0;
        end else begin
          tx_mem[tx_wr] = {addr, op[0]};
          tx_written[tx_wr] = 1'b1;
          tx_wr = tx_wr + 4'd1;
          tx_pushed = 1'b1;
          r.command = CMD_START;
        end
      end
      OP_QUEUE_BYTE: begin
        if (tx_is_empty()) begin
          // straight to the engine; the slot is counted but not written
          tx_wr = tx_wr + 4'd1;
          tx_pushed = 1'b1;
          r.load_data = 1'b1;
          r.tx_byte = hbyte;
          r.command = CMD_SEND;
        end else if (tx_wr == tx_rd) begin
          r.accepted = 1'b0;
        end else begin
          tx_mem[tx_wr] = hbyte;
          tx_written[tx_wr] = 1'b1;
          tx_wr = tx_wr + 4'd1;
          tx_pushed = 1'b1;
        end
      end
      OP_REQUEST: begin
        sum = {1'b0, pend_count} + {1'b0, count};
        pend_count = sum[8] ? 8'hFF : sum[7:0];
      end
      OP_POP: begin
        if (!rx_is_empty()) begin
          r.popped = rx_mem[rx_rd];
          rx_rd = rx_rd + 4'd1;
          rx_pushed = 1'b0;
        end
      end
      OP_END_WRITE: begin
        if (!tx_is_empty()) r.accepted = 1'b0;
        else r.command = CMD_STOP;
      end
      OP_END_READ: begin
        if (pend_count != 8'd0) r.accepted = 1'b0;
        else r.command = CMD_STOP;
      end
      default: begin
        k = kind_of(status);
        if (k == EV_START || k == EV_TX_DONE) begin
          if (k == EV_TX_DONE && !tx_is_empty()) begin
            tx_rd = tx_rd + 4'd1;
            tx_pushed = 1'b0;
          end
          if (!tx_is_empty()) begin
            r.load_data = 1'b1;
            r.tx_byte = tx_mem[tx_rd];
            r.command = CMD_CONTINUE;
          end else if (pend_count == 8'd1) begin
            r.command = CMD_NACK;
          end else if (pend_count > 8'd1) begin
            r.command = CMD_CONTINUE;
          end else begin
            r.command = CMD_RELEASE;
          end
        end else if (k == EV_RECEIVE) begin
          if (pend_count != 8'd0) begin
            // full queue: overwrite the oldest byte and keep it full
            if (rx_wr == rx_rd && rx_pushed) begin
              rx_rd = rx_rd + 4'd1;
              r.overrun = 1'b1;
            end
            rx_mem[rx_wr] = rx_byte;
            rx_wr = rx_wr + 4'd1;
            rx_pushed = 1'b1;
            pend_count = pend_count - 8'd1;
          end
          if (pend_count > 8'd1) r.command = CMD_ACK;
          else if (pend_count == 8'd1) r.command = CMD_NACK;
          else r.command = CMD_RELEASE;
        end else begin
          r.command = CMD_CONTINUE;
        end
      end
    endcase
    r.rx_available = !rx_is_empty();
    r.pending = pend_count;
    return r;
  endfunction

  function automatic logic [7:0] pick_status(input logic [4:0] a, input logic [4:0] b);
    return {($urandom_range(0, 1) != 0) ? a : b, 3'($urandom)};
  endfunction

  task automatic flag_error(input string msg);
    if (error_count < MAX_PRINTED) $display("ERROR %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) flag_error($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Send one transfer. arg lands in the field that op uses; every other field
  // gets random bits. Called at a rising edge, returns at the accepting edge.
  task automatic send_item(input logic [2:0] op, input logic [7:0] arg);
    logic [6:0] addr;
    logic [7:0] hbyte, count, status, rx_byte;
    addr = 7'($urandom);
    hbyte = 8'($urandom);
    count = 8'($urandom);
    status = 8'($urandom);
    rx_byte = 8'($urandom);
    case (op)
      OP_BEGIN_WRITE, OP_BEGIN_READ: addr = arg[6:0];
      OP_QUEUE_BYTE: hbyte = arg;
      OP_REQUEST: count = arg;
      OP_BUS_EVENT: status = reads_unwritten_slot(arg) ? {SC_ARB_LOST, arg[2:0]} : arg;
      default: ;
    endcase
    if (idle_on && $urandom_range(0, 99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_slave_address <= addr;
    in_host_byte <= hbyte;
    in_request_count <= count;
    in_bus_status <= status;
    in_bus_rx_byte <= rx_byte;
    do @(posedge clk); while (busy);
    engine_replies.push_back(predict_sequencer(op, addr, hbyte, count, status, rx_byte));
    items_sent++;
  endtask

  // Stop sending until every predicted reply has come back.
  task automatic hold_until_quiet();
    start <= 1'b0;
    do @(posedge clk); while (engine_replies.size() != 0);
  endtask

  task automatic drain_transmit();
    while (!tx_is_empty())
      send_item(OP_BUS_EVENT, pick_status(SC_MT_DATA_ACK, SC_MT_DATA_NACK));
  endtask

  // Write path: blocked begin and end, queued byte, direct send, highest
  // address, status low bits ignored.
  task automatic test_write_path();
    send_item(OP_END_WRITE, 8'h00);                   // nothing queued: stop at once
    send_item(OP_BEGIN_WRITE, 8'h7F);
    send_item(OP_BEGIN_READ, 8'h55);                  // queue busy: refused
    send_item(OP_QUEUE_BYTE, 8'hFF);
    send_item(OP_BUS_EVENT, {SC_START, 3'b000});      // loads the address byte
    send_item(OP_BUS_EVENT, {SC_MT_SLA_ACK, 3'b000}); // loads 0xFF
    send_item(OP_END_WRITE, 8'h00);                   // refused, byte still queued
    send_item(OP_BUS_EVENT, {SC_MT_DATA_ACK, 3'b000});
    send_item(OP_END_WRITE, 8'h00);
    send_item(OP_QUEUE_BYTE, 8'h00);                  // empty queue: direct send
    send_item(OP_BUS_EVENT, {SC_MT_DATA_NACK, 3'b111});
  endtask

  // Read path: request counts, nack on last byte, drop with nothing pending,
  // pops incl. empty, refused end read, unknown status codes.
  task automatic test_read_path();
    send_item(OP_BEGIN_READ, 8'h00);
    send_item(OP_BUS_EVENT, {SC_RESTART, 3'b101});
    send_item(OP_REQUEST, 8'd0);
    send_item(OP_REQUEST, 8'd2);
    send_item(OP_BUS_EVENT, {SC_MR_SLA_ACK, 3'b000}); // queue empty, two pending
    send_item(OP_END_READ, 8'h00);                    // refused
    send_item(OP_BUS_EVENT, {SC_MR_DATA_ACK, 3'b010});
    send_item(OP_BUS_EVENT, {SC_MR_DATA_NACK, 3'b000});
    send_item(OP_BUS_EVENT, {SC_MR_DATA_NACK, 3'b000}); // nothing pending: dropped
    send_item(OP_POP, 8'h00);
    send_item(OP_POP, 8'h00);
    send_item(OP_POP, 8'h00);                         // empty: reads zero
    send_item(OP_END_READ, 8'h00);
    send_item(OP_BUS_EVENT, 8'hF8);
    send_item(OP_BUS_EVENT, 8'h00);
    send_item(OP_BUS_EVENT, {SC_MR_SLA_NACK, 3'b000}); // address nack with empty queue: release
    send_item(OP_REQUEST, 8'd1);
    send_item(OP_BUS_EVENT, {SC_MT_DATA_ACK, 3'b000}); // one pending: nack
    send_item(OP_BUS_EVENT, {SC_MR_DATA_ACK, 3'b000});
  endtask

  // Full transmit queue, saturated pending count and receive overruns.
  task automatic test_queue_limits();
    send_item(OP_BEGIN_WRITE, 8'($urandom));
    repeat (16) send_item(OP_QUEUE_BYTE, 8'($urandom)); // last one is refused
    send_item(OP_END_WRITE, 8'h00);
    send_item(OP_BUS_EVENT, pick_status(SC_START, SC_RESTART));
    drain_transmit();
    send_item(OP_END_WRITE, 8'h00);
    send_item(OP_REQUEST, 8'd200);
    send_item(OP_REQUEST, 8'd100);                    // saturates at 255
    for (int i = 0; i < 255; i++) begin
      send_item(OP_BUS_EVENT, pick_status(SC_MR_DATA_ACK, SC_MR_DATA_NACK));
      if (i % 40 == 39) send_item(OP_POP, 8'h00);
    end
    while (!rx_is_empty()) send_item(OP_POP, 8'h00);
    send_item(OP_END_READ, 8'h00);
  endtask

  task automatic run_write_transfer();
    int unsigned n;
    if ($urandom_range(0, 1) != 0) drain_transmit();
    send_item(OP_BEGIN_WRITE, 8'($urandom));
    send_item(OP_BUS_EVENT, pick_status(SC_START, SC_RESTART));
    n = $urandom_range(0, 18);
    repeat (n) begin
      send_item(OP_QUEUE_BYTE, 8'($urandom));
      if ($urandom_range(0, 2) == 0)
        send_item(OP_BUS_EVENT, pick_status(SC_MT_SLA_ACK, SC_MT_DATA_ACK));
    end
    if ($urandom_range(0, 3) == 0) send_item(OP_END_WRITE, 8'($urandom));
    drain_transmit();
    send_item(OP_END_WRITE, 8'($urandom));
  endtask

  task automatic run_read_transfer();
    if ($urandom_range(0, 3) != 0) drain_transmit();
    send_item(OP_BEGIN_READ, 8'($urandom));
    send_item(OP_BUS_EVENT, pick_status(SC_START, SC_RESTART));
    send_item(OP_REQUEST, 8'($urandom_range(1, 20)));
    send_item(OP_BUS_EVENT, pick_status(SC_MR_SLA_ACK, SC_MR_SLA_NACK));
    while (pend_count != 8'd0) begin
      if ($urandom_range(0, 3) == 0) send_item(OP_POP, 8'($urandom));
      else send_item(OP_BUS_EVENT, pick_status(SC_MR_DATA_ACK, SC_MR_DATA_NACK));
    end
    if ($urandom_range(0, 3) == 0)
      send_item(OP_BUS_EVENT, pick_status(SC_MR_DATA_ACK, SC_MR_DATA_NACK));
    while (!rx_is_empty() && $urandom_range(0, 7) != 0) send_item(OP_POP, 8'($urandom));
    send_item(OP_END_READ, 8'($urandom));
  endtask

  // Mostly well-formed write and read transfers with random content, plus
  // bursts of fully random operations. A stretch in the middle runs back to back.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned base;
    int unsigned pick;
    base = items_sent;
    while (items_sent - base < n_items) begin
      idle_on = !(items_sent - base >= 600 && items_sent - base < 900);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        run_write_transfer();
      end else if (pick < 85) begin
        run_read_transfer();
      end else begin
        repeat ($urandom_range(1, 3))
          send_item(3'($urandom_range(0, 7)), 8'($urandom));
      end
      if ($urandom_range(0, 9) == 0) hold_until_quiet();
    end
    idle_on = 1'b1;
  endtask

  // Reply checker: each out_valid cycle is one reply, matched in order.
  always @(posedge clk) begin
    engine_reply_t want;
    if (rst_n && out_valid) begin
      if (engine_replies.size() == 0) begin
        flag_error("reply with no transfer outstanding");
      end else begin
        want = engine_replies.pop_front();
        check_field("accepted", 8'(out_accepted), 8'(want.accepted));
        check_field("bus_command", 8'(out_bus_command), 8'(want.command));
        check_field("load_data", 8'(out_load_data), 8'(want.load_data));
        check_field("tx_byte_out", out_tx_byte_out, want.tx_byte);
        check_field("popped_byte", out_popped_byte, want.popped);
        check_field("rx_available", 8'(out_rx_available), 8'(want.rx_available));
        check_field("pending_receive", out_pending_receive, want.pending);
        check_field("overrun", 8'(out_overrun), 8'(want.overrun));
      end
    end
  end

  // Hang detection: any transfer in or reply out resets the count.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= HANG_LIMIT) begin
      $display("FAIL i2c_master_transfer_queue_top");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_operation <= OP_POP;
    in_slave_address <= '0;
    in_host_byte <= '0;
    in_request_count <= '0;
    in_bus_status <= '0;
    in_bus_rx_byte <= '0;
    items_sent = 0;
    error_count = 0;
    idle_on = 1'b1;
    tx_written = '0;
    tx_wr = '0;
    tx_rd = '0;
    tx_pushed = 1'b0;
    rx_wr = '0;
    rx_rd = '0;
    rx_pushed = 1'b0;
    pend_count = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_write_path();
    test_read_path();
    test_queue_limits();
    test_random_traffic(1400);
    hold_until_quiet();
    repeat (6) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS i2c_master_transfer_queue_top");
    end else begin
      $display("FAIL i2c_master_transfer_queue_top");
    end
    $finish;
  end

endmodule
